>>> src/ppm_sum_frame_decoder_assert.svh
// ----------------------------------------------------------------------------
// PPM-sum decoder assertion macros
// Short forms for the concurrent checks used across the decoder modules.
// ----------------------------------------------------------------------------
`ifndef PPM_SUM_FRAME_DECODER_ASSERT_SVH
`define PPM_SUM_FRAME_DECODER_ASSERT_SVH

// cond implies cons in the same cycle
`define PSFD_ASSERT_IMPL(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// cond implies cons in the following cycle
`define PSFD_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

// cond never holds
`define PSFD_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

>>> src/psfd_pkg.sv
// ----------------------------------------------------------------------------
// PPM-sum frame decoder package
// Field widths, register indexes, event codes and the transaction types
// shared by the decoder modules.
// ----------------------------------------------------------------------------
package psfd_pkg;

   localparam int TIME_W     = 16;
   localparam int PULSE_W    = 12;
   localparam int PERIOD_W   = 15;
   localparam int SYNC_W     = 15;
   localparam int CNT_W      = 5;
   localparam int FS_W       = 8;
   localparam int JIT_W      = 8;
   localparam int IDX_W      = 4;
   localparam int FILT_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PULSE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PULSE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SYNC  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CHAN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_JITTER    = 3'd5;

   // register reset values
   localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 12'd900;
   localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 12'd2100;
   localparam logic [SYNC_W-1:0]  MIN_SYNC_RST  = 15'd2700;
   localparam logic [CNT_W-1:0]   MAX_CHAN_RST  = 5'd16;
   localparam logic [JIT_W-1:0]   JITTER_RST    = 8'd4;

   // filter modes; the unused code stores raw
   localparam logic [FILT_W-1:0] FILT_RAW    = 2'd0;
   localparam logic [FILT_W-1:0] FILT_AVG    = 2'd1;
   localparam logic [FILT_W-1:0] FILT_JITTER = 2'd2;

   localparam logic [PULSE_W-1:0] SLOT_RESET_VALUE   = 12'd1500;
   localparam logic [CNT_W-1:0]   MIN_FRAME_CHANNELS = 5'd3;
   localparam logic [CNT_W-1:0]   CNT_MAX            = 5'd31;
   localparam logic [FS_W-1:0]    FS_MAX             = 8'd255;

   typedef enum logic [2:0] {
      EV_IGNORED     = 3'd0,
      EV_STORED      = 3'd1,
      EV_OVERFLOW    = 3'd2,
      EV_TOO_MANY    = 3'd3,
      EV_FIRST_SYNC  = 3'd4,
      EV_FRAME       = 3'd5,
      EV_SHORT_FRAME = 3'd6,
      EV_BAD_PULSE   = 3'd7
   } event_type;

   typedef enum logic {
      BK_IDLE,
      BK_EMIT
   } bk_state_type;

   typedef struct packed {
      logic [TIME_W-1:0] edge_time;
      logic              pin_level;
   } req_type;

   typedef struct packed {
      event_type          event_res;
      logic [IDX_W-1:0]   channel_index;
      logic [PULSE_W-1:0] channel_value;
      logic [CNT_W-1:0]   channel_count;
      logic [FS_W-1:0]    failsafe_count;
      logic               frame_valid;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic                  valid;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_type;

   // classified edge handed from front to back
   typedef struct packed {
      logic               rising;
      logic               in_window;
      logic               over_sync;
      logic [PULSE_W-1:0] period;
   } cmd_type;

endpackage

>>> src/psfd_fifo.sv
// ----------------------------------------------------------------------------
// PPM-sum decoder queue
// Small first-in first-out buffer of register entries with full and empty.
// ----------------------------------------------------------------------------
module psfd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   `include "ppm_sum_frame_decoder_assert.svh"

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   `PSFD_ASSERT_NEVER(a_fifo_no_overflow, clock, reset, push && full, "push into full queue")
   `PSFD_ASSERT_NEVER(a_fifo_no_underflow, clock, reset, pop && empty, "pop from empty queue")
   `PSFD_ASSERT_NEXT(a_fifo_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "queue count did not advance on push")

endmodule

>>> src/psfd_front.sv
// ----------------------------------------------------------------------------
// PPM-sum decoder front end
// Takes edges, measures the interval between rising edges in microseconds
// and classifies it against the pulse window and the sync gap.
// ----------------------------------------------------------------------------
module psfd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  psfd_pkg::req_type req_data,
   input  psfd_pkg::csr_type csr,
   input  logic              cmd_full,
   output logic              cmd_push,
   output psfd_pkg::cmd_type cmd_data
);
   import psfd_pkg::*;

   logic [TIME_W-1:0]  last_edge_ff, last_edge_in;
   logic [PULSE_W-1:0] min_pulse_ff, min_pulse_in;
   logic [PULSE_W-1:0] max_pulse_ff, max_pulse_in;
   logic [SYNC_W-1:0]  min_sync_ff, min_sync_in;

   logic [TIME_W-1:0]   delta;
   logic [PERIOD_W-1:0] period;

   // interval wraps modulo the timer width, then drop the half-tick bit
   assign delta  = req_data.edge_time - last_edge_ff;
   assign period = delta[TIME_W-1:1];

   assign cmd_push = req_push && !cmd_full;

   always_comb begin
      cmd_data.rising    = req_data.pin_level;
      cmd_data.in_window = (period < PERIOD_W'(max_pulse_ff)) &&
                           (period > PERIOD_W'(min_pulse_ff));
      cmd_data.over_sync = (period > min_sync_ff);
      // only consumed when inside the window, so it fits the slot width
      cmd_data.period    = period[PULSE_W-1:0];
   end

   always_comb begin
      last_edge_in = last_edge_ff;
      if (cmd_push && req_data.pin_level) begin
         last_edge_in = req_data.edge_time;
      end
   end

   always_comb begin
      min_pulse_in = min_pulse_ff;
      max_pulse_in = max_pulse_ff;
      min_sync_in  = min_sync_ff;
      if (csr.valid) begin
         case (csr.index)
            CSR_MIN_PULSE: min_pulse_in = csr.data[PULSE_W-1:0];
            CSR_MAX_PULSE: max_pulse_in = csr.data[PULSE_W-1:0];
            CSR_MIN_SYNC:  min_sync_in  = csr.data[SYNC_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_edge_ff <= '0;
         min_pulse_ff <= MIN_PULSE_RST;
         max_pulse_ff <= MAX_PULSE_RST;
         min_sync_ff  <= MIN_SYNC_RST;
      end else begin
         last_edge_ff <= last_edge_in;
         min_pulse_ff <= min_pulse_in;
         max_pulse_ff <= max_pulse_in;
         min_sync_ff  <= min_sync_in;
      end
   end

endmodule

>>> src/psfd_back.sv
// ----------------------------------------------------------------------------
// PPM-sum decoder back end
// Runs the sync and channel state, filters pulses into the slot registers
// and sweeps the slots out as one result per slot on a frame.
// ----------------------------------------------------------------------------
module psfd_back #(
   parameter int NUM_CHANNEL_SLOTS = 8,
   parameter int AVERAGE_WEIGHT    = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  psfd_pkg::csr_type csr,
   input  logic              cmd_empty,
   input  psfd_pkg::cmd_type cmd_data,
   output logic              cmd_pop,
   input  logic              rsp_full,
   output logic              rsp_push,
   output psfd_pkg::rsp_type rsp_data
);
   import psfd_pkg::*;
   `include "ppm_sum_frame_decoder_assert.svh"

   localparam int SLOT_W    = $clog2(NUM_CHANNEL_SLOTS);
   localparam int AVG_DIV   = AVERAGE_WEIGHT + 1;
   localparam int AVG_SHIFT = 17;
   // rounded-up reciprocal; exact for SUM_W-bit sums while AVG_DIV <= 8
   localparam int AVG_RECIP = (2 ** AVG_SHIFT + AVG_DIV - 1) / AVG_DIV;
   localparam int SUM_W     = 14;
   localparam int PROD_W    = 32;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_CHANNEL_SLOTS - 1);

   bk_state_type       state_ff, state_in;
   logic               sync_ff, sync_in;
   logic [CNT_W-1:0]   counter_ff, counter_in;
   logic               fv_ff, fv_in;
   logic [FS_W-1:0]    short_ff, short_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [PULSE_W-1:0] raw_ff [NUM_CHANNEL_SLOTS];
   logic [PULSE_W-1:0] raw_in [NUM_CHANNEL_SLOTS];
   logic [CNT_W-1:0]   max_chan_ff, max_chan_in;
   logic [FILT_W-1:0]  filter_ff, filter_in;
   logic [JIT_W-1:0]   jitter_ff, jitter_in;

   logic               cmd_take;
   logic               is_frame_cmd;
   logic               slot_free;
   logic [CNT_W:0]     next_count;
   logic [SLOT_W-1:0]  wr_slot;
   logic [SLOT_W-1:0]  rd_slot;
   logic [PULSE_W-1:0] rd_val;
   logic [SUM_W-1:0]   avg_sum;
   logic [PROD_W-1:0]  avg_prod;
   logic [PULSE_W-1:0] avg_val;
   logic [PULSE_W-1:0] jit_diff;
   logic [PULSE_W-1:0] store_val;
   event_type          ev;
   logic [IDX_W-1:0]   res_idx;
   logic [PULSE_W-1:0] res_val;
   logic               res_last;

   assign cmd_take     = (state_ff == BK_IDLE) && !cmd_empty && !rsp_full;
   assign is_frame_cmd = cmd_data.rising && cmd_data.over_sync && sync_ff &&
                         !cmd_data.in_window && (counter_ff > MIN_FRAME_CHANNELS);
   assign slot_free    = (counter_ff < CNT_W'(NUM_CHANNEL_SLOTS));
   assign next_count   = {1'b0, counter_ff} + 1'b1;
   assign wr_slot      = counter_ff[SLOT_W-1:0];
   // one read port: the sweep slot while emitting, else the pulse slot
   assign rd_slot      = (state_ff == BK_EMIT) ? slot_ff : wr_slot;
   assign rd_val       = raw_ff[rd_slot];

   // pulse filter
   assign avg_sum  = SUM_W'(rd_val) * SUM_W'(AVERAGE_WEIGHT) + SUM_W'(cmd_data.period);
   assign avg_prod = PROD_W'(avg_sum) * PROD_W'(AVG_RECIP);
   assign avg_val  = avg_prod[AVG_SHIFT +: PULSE_W];
   assign jit_diff = (rd_val > cmd_data.period) ? rd_val - cmd_data.period
                                                : cmd_data.period - rd_val;

   always_comb begin
      case (filter_ff)
         FILT_AVG:    store_val = avg_val;
         FILT_JITTER: store_val = (jit_diff > PULSE_W'(jitter_ff)) ? cmd_data.period
                                                                    : rd_val;
         default:     store_val = cmd_data.period;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_take && is_frame_cmd) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (!rsp_full && slot_ff == LAST_SLOT) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // decoder state update and result
   always_comb begin
      sync_in    = sync_ff;
      counter_in = counter_ff;
      fv_in      = fv_ff;
      short_in   = short_ff;
      slot_in    = slot_ff;
      raw_in     = raw_ff;
      cmd_pop    = 1'b0;
      rsp_push   = 1'b0;
      ev         = EV_IGNORED;
      res_idx    = '0;
      res_val    = '0;
      res_last   = 1'b1;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_take) begin
               cmd_pop  = 1'b1;
               rsp_push = !is_frame_cmd;
               if (!cmd_data.rising) begin
                  ev = EV_IGNORED;
               end else if (cmd_data.in_window && sync_ff) begin
                  if (slot_free) begin
                     raw_in[wr_slot] = store_val;
                     ev = EV_STORED;
                  end else begin
                     ev = EV_OVERFLOW;
                  end
                  if (next_count > {1'b0, max_chan_ff}) begin
                     fv_in   = 1'b0;
                     sync_in = 1'b0;
                     ev      = EV_TOO_MANY;
                  end
                  counter_in = next_count[CNT_W] ? CNT_MAX : next_count[CNT_W-1:0];
               end else if (cmd_data.over_sync && !sync_ff) begin
                  sync_in    = 1'b1;
                  counter_in = '0;
                  fv_in      = 1'b0;
                  ev         = EV_FIRST_SYNC;
               end else if (cmd_data.over_sync) begin
                  counter_in = '0;
                  if (is_frame_cmd) begin
                     // latch the frame; the sweep emits the slots
                     fv_in    = 1'b1;
                     short_in = '0;
                     slot_in  = '0;
                  end else begin
                     if (short_ff != FS_MAX) begin
                        short_in = short_ff + 1'b1;
                     end
                     fv_in = 1'b0;
                     ev    = EV_SHORT_FRAME;
                  end
               end else begin
                  counter_in = '0;
                  fv_in      = 1'b0;
                  sync_in    = 1'b0;
                  ev         = EV_BAD_PULSE;
               end
            end
         end
         BK_EMIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               ev       = EV_FRAME;
               res_idx  = IDX_W'(slot_ff);
               res_val  = rd_val;
               res_last = (slot_ff == LAST_SLOT);
               slot_in  = slot_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_data.event_res      = ev;
      rsp_data.channel_index  = res_idx;
      rsp_data.channel_value  = res_val;
      rsp_data.channel_count  = counter_in;
      rsp_data.failsafe_count = short_in;
      rsp_data.frame_valid    = fv_in;
      rsp_data.last           = res_last;
   end

   always_comb begin
      max_chan_in = max_chan_ff;
      filter_in   = filter_ff;
      jitter_in   = jitter_ff;
      if (csr.valid) begin
         case (csr.index)
            CSR_MAX_CHAN: max_chan_in = csr.data[CNT_W-1:0];
            CSR_FILTER:   filter_in   = csr.data[FILT_W-1:0];
            CSR_JITTER:   jitter_in   = csr.data[JIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_IDLE;
         sync_ff     <= 1'b0;
         counter_ff  <= '0;
         fv_ff       <= 1'b0;
         short_ff    <= '0;
         slot_ff     <= '0;
         max_chan_ff <= MAX_CHAN_RST;
         filter_ff   <= FILT_RAW;
         jitter_ff   <= JITTER_RST;
         for (int i = 0; i < NUM_CHANNEL_SLOTS; i++) begin
            raw_ff[i] <= SLOT_RESET_VALUE;
         end
      end else begin
         state_ff    <= state_in;
         sync_ff     <= sync_in;
         counter_ff  <= counter_in;
         fv_ff       <= fv_in;
         short_ff    <= short_in;
         slot_ff     <= slot_in;
         max_chan_ff <= max_chan_in;
         filter_ff   <= filter_in;
         jitter_ff   <= jitter_in;
         raw_ff      <= raw_in;
      end
   end

   `PSFD_ASSERT_NEVER(a_no_take_while_emit, clock, reset, (state_ff == BK_EMIT) && cmd_pop, "edge taken during frame sweep")
   `PSFD_ASSERT_NEXT(a_frame_entry, clock, reset, cmd_take && is_frame_cmd, fv_ff && (counter_ff == '0) && (slot_ff == '0) && (state_ff == BK_EMIT), "frame sweep entered with wrong state")
   `PSFD_ASSERT_IMPL(a_sync_drop_invalid, clock, reset, $fell(sync_ff), !fv_ff, "sync dropped with frame still valid")
   `PSFD_ASSERT_IMPL(a_sweep_result, clock, reset, rsp_push && (state_ff == BK_EMIT), (rsp_data.event_res == EV_FRAME) && fv_ff, "sweep result without valid frame")

endmodule

>>> src/ppm_sum_frame_decoder.sv
// ----------------------------------------------------------------------------
// PPM-sum frame decoder
// Decodes timestamped edges of a PPM-sum signal into per-channel pulse
// widths and emits the latched frame one slot per result.
//
//   channel  direction  handshake             payload
//   req      in         req_push / req_full   req_data  (psfd_pkg::req_type)
//   rsp      out        rsp_pop / rsp_empty   rsp_data  (psfd_pkg::rsp_type)
//   csr      in         csr_valid / csr_ready csr_index, csr_wdata
//
// The front takes one edge per cycle, while there is room, into a
// two-entry command queue. The back gives the result of an edge in the
// cycle it takes it; a frame edge starts the slot sweep instead, one
// result per slot. Results wait in a four-entry queue; a full queue stalls
// the back, and once the command queue has filled behind it, the input as
// well. Reset loads every slot with 1500 us.
// csr_ready is always high.
// ----------------------------------------------------------------------------
module ppm_sum_frame_decoder #(
   parameter int NUM_CHANNEL_SLOTS = 8,
   parameter int AVERAGE_WEIGHT    = 1
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  psfd_pkg::req_type                     req_data,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output psfd_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [psfd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [psfd_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import psfd_pkg::*;

   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 4;
   localparam int CMD_W     = $bits(cmd_type);
   localparam int RSP_W     = $bits(rsp_type);

   csr_type          csr;
   cmd_type          cmd_wdata;
   cmd_type          cmd_rdata;
   logic [CMD_W-1:0] cmd_rvec;
   logic             cmd_push;
   logic             cmd_pop;
   logic             cmd_full;
   logic             cmd_empty;
   rsp_type          rsp_wdata;
   logic [RSP_W-1:0] rsp_rvec;
   logic             rsp_push;
   logic             rsp_full;

   assign csr_ready = 1'b1;
   always_comb begin
      csr.valid = csr_valid && csr_ready;
      csr.index = csr_index;
      csr.data  = csr_wdata;
   end

   assign req_full  = cmd_full;
   assign cmd_rdata = cmd_rvec;
   assign rsp_data  = rsp_rvec;

   psfd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .csr      (csr),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd_data (cmd_wdata)
   );

   psfd_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wdata),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_rvec),
      .empty (cmd_empty)
   );

   psfd_back #(
      .NUM_CHANNEL_SLOTS (NUM_CHANNEL_SLOTS),
      .AVERAGE_WEIGHT    (AVERAGE_WEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_rdata),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_wdata)
   );

   psfd_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_wdata),
      .full  (rsp_full),
      .pop   (rsp_pop && !rsp_empty),
      .rdata (rsp_rvec),
      .empty (rsp_empty)
   );

endmodule
